>>> src/sll_pkg.sv
// package for the script language lexer: token codes, modes, payload types
package sll_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KW_LEN = 8;
    localparam int MAX_RES = 3;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING,
        M_SLASH, M_STAR, M_EQ, M_LT, M_GT, M_BANG
    } mode_t;

    localparam logic [5:0] K_LPAREN     = 6'd0;
    localparam logic [5:0] K_RPAREN     = 6'd1;
    localparam logic [5:0] K_SEMI       = 6'd2;
    localparam logic [5:0] K_COMMA      = 6'd3;
    localparam logic [5:0] K_DOT        = 6'd4;
    localparam logic [5:0] K_MINUS      = 6'd5;
    localparam logic [5:0] K_PLUS       = 6'd6;
    localparam logic [5:0] K_SLASH      = 6'd7;
    localparam logic [5:0] K_SLASH2     = 6'd8;
    localparam logic [5:0] K_STAR       = 6'd9;
    localparam logic [5:0] K_STAR2      = 6'd10;
    localparam logic [5:0] K_PERCENT    = 6'd11;
    localparam logic [5:0] K_BANG_EQ    = 6'd12;
    localparam logic [5:0] K_EQ         = 6'd13;
    localparam logic [5:0] K_EQ_EQ      = 6'd14;
    localparam logic [5:0] K_LESS       = 6'd15;
    localparam logic [5:0] K_LESS_EQ    = 6'd16;
    localparam logic [5:0] K_GREATER    = 6'd17;
    localparam logic [5:0] K_GREATER_EQ = 6'd18;
    localparam logic [5:0] K_IDENT      = 6'd19;
    localparam logic [5:0] K_STRING     = 6'd20;
    localparam logic [5:0] K_NUMBER     = 6'd21;
    localparam logic [5:0] K_KW_BASE    = 6'd22;
    localparam logic [5:0] K_EOF        = 6'd38;
    localparam logic [5:0] K_ERR_CHAR   = 6'd39;
    localparam logic [5:0] K_ERR_STRING = 6'd40;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } out_item_t;

    // one token before the last-of-run mark is set
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } tok_t;

    typedef logic [KW_LEN-1:0][7:0] kwbuf_t;

    // keyword table, bytes beyond the word are zero
    function automatic logic [5:0] kw_lookup(input kwbuf_t b, input logic [3:0] len);
        logic [5:0] k;
        k = K_IDENT;
        case (len)
            4'd2: begin
                if (b[0] == "i" && b[1] == "f") k = K_KW_BASE + 6'd9;
                if (b[0] == "o" && b[1] == "r") k = K_KW_BASE + 6'd12;
            end
            4'd3: begin
                if (b[0] == "a" && b[1] == "n" && b[2] == "d") k = K_KW_BASE + 6'd0;
                if (b[0] == "d" && b[1] == "e" && b[2] == "f") k = K_KW_BASE + 6'd3;
                if (b[0] == "e" && b[1] == "n" && b[2] == "d") k = K_KW_BASE + 6'd6;
                if (b[0] == "f" && b[1] == "o" && b[2] == "r") k = K_KW_BASE + 6'd8;
                if (b[0] == "n" && b[1] == "o" && b[2] == "t") k = K_KW_BASE + 6'd11;
            end
            4'd4: begin
                if (b[3:0] == {"f", "i", "l", "e"}) k = K_KW_BASE + 6'd4;
                if (b[3:0] == {"e", "s", "l", "e"}) k = K_KW_BASE + 6'd5;
                if (b[3:0] == {"e", "n", "o", "n"}) k = K_KW_BASE + 6'd10;
                if (b[3:0] == {"e", "u", "r", "t"}) k = K_KW_BASE + 6'd14;
            end
            4'd5: begin
                if (b[4:0] == {"k", "a", "e", "r", "b"}) k = K_KW_BASE + 6'd1;
                if (b[4:0] == {"e", "s", "l", "a", "f"}) k = K_KW_BASE + 6'd7;
                if (b[4:0] == {"e", "l", "i", "h", "w"}) k = K_KW_BASE + 6'd15;
            end
            4'd6: begin
                if (b[5:0] == {"n", "r", "u", "t", "e", "r"}) k = K_KW_BASE + 6'd13;
            end
            4'd8: begin
                if (b == {"e", "u", "n", "i", "t", "n", "o", "c"}) k = K_KW_BASE + 6'd2;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

>>> src/script_language_lexer.sv
// top level of the script language lexer
//
// Byte-stream lexer. Source bytes enter on in_valid/in_stall with payload in_item
// (char_code, end_of_input). Tokens leave on out_valid/out_stall with payload
// out_item (kind, start, length, line, last_of_run). A byte produces zero to
// three tokens; last_of_run marks the final token of a byte.
// Throughput: one byte per cycle while the token queue has room for a full
// group of three; tokens leave at one per cycle, so bursts of bytes with many
// tokens each are paced by the output side.
// Tokens of an accepted byte are registered in the queue and reach the output once the tokens ahead of them have left.
// Scanning state updates combinationally from the accepted byte into the mode,
// offset, line and keyword registers in the same cycle.
// End of input (flag or zero byte) flushes the pending token, emits an
// end-of-file token and returns the scanner to its reset state.
// Reset (rst_n low) empties the queue and sets line 1, offset 0, idle mode.
// While the receiver stalls, the head token holds and input stalls once the
// queue cannot take another group.
module script_language_lexer #(
    parameter int POSITION_BITS = sll_pkg::POSITION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sll_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sll_pkg::out_item_t out_item
);
    logic step, space_ok;
    logic [1:0] cnt;
    sll_pkg::tok_t t0, t1, t2;

    assign in_stall = !space_ok;
    assign step = in_valid && space_ok;

    sll_core #(.POSITION_BITS(POSITION_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .in_item(in_item),
        .tok_count(cnt), .tok0(t0), .tok1(t1), .tok2(t2)
    );

    sll_outq u_q (
        .clk(clk), .rst_n(rst_n), .push(step && cnt != 2'd0), .push_count(cnt),
        .push0(t0), .push1(t1), .push2(t2), .space_ok(space_ok),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );
endmodule

>>> src/sll_core.sv
// per-byte scanning step: mode and counters, up to three tokens
module sll_core #(
    parameter int POSITION_BITS = sll_pkg::POSITION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  sll_pkg::in_item_t in_item,
    output logic [1:0]       tok_count,
    output sll_pkg::tok_t    tok0,
    output sll_pkg::tok_t    tok1,
    output sll_pkg::tok_t    tok2
);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam int SB = (POSITION_BITS < 16) ? POSITION_BITS : 16;

    sll_pkg::mode_t mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next, pos_reg, pos_next, dot_reg, dot_next;
    logic [15:0] line_reg, line_next;
    sll_pkg::kwbuf_t kw_reg, kw_next;

    logic [7:0] c;
    logic eoi, alpha, digit, cont;
    logic [15:0] line_up;
    sll_pkg::tok_t t [3];
    logic [1:0] n;

    // saturating span clipped to 16 bits
    function automatic logic [15:0] span16(input logic [POSITION_BITS-1:0] from,
                                           input logic [POSITION_BITS-1:0] to,
                                           input logic plus1);
        logic [POSITION_BITS:0] d;
        d = (to >= from) ? ({1'b0, to} - {1'b0, from} + {{POSITION_BITS{1'b0}}, plus1})
                         : {{POSITION_BITS{1'b0}}, plus1};
        if (d > (POSITION_BITS+1)'(17'hFFFF)) return 16'hFFFF;
        return 16'(d);
    endfunction

    function automatic logic [15:0] lo16(input logic [POSITION_BITS-1:0] v);
        logic [15:0] r;
        r = '0;
        r[SB-1:0] = v[SB-1:0];
        return r;
    endfunction

    always_comb
    begin
        sll_pkg::tok_t tk;
        logic [POSITION_BITS-1:0] idx;
        c = in_item.char_code;
        eoi = in_item.end_of_input || (c == 8'd0);
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        digit = c >= "0" && c <= "9";
        line_up = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
        mode_next = mode_reg;
        start_next = start_reg;
        pos_next = pos_reg;
        dot_next = dot_reg;
        line_next = line_reg;
        kw_next = kw_reg;
        t[0] = '0; t[1] = '0; t[2] = '0;
        n = 2'd0;
        cont = 1'b0;
        idx = pos_reg - start_reg;
        tk = '0;

        // continue the pending token
        if (!eoi)
        begin
            case (mode_reg)
                sll_pkg::M_COMMENT: cont = c != 8'h0A;
                sll_pkg::M_IDENT:
                begin
                    if (alpha || digit)
                    begin
                        cont = 1'b1;
                        if (pos_reg >= start_reg && idx < POSITION_BITS'(sll_pkg::KW_LEN))
                            kw_next[idx[2:0]] = c;
                    end
                end
                sll_pkg::M_INT:
                begin
                    if (digit) cont = 1'b1;
                    else if (c == ".")
                    begin
                        cont = 1'b1;
                        dot_next = pos_reg;
                        mode_next = sll_pkg::M_DOT;
                    end
                end
                sll_pkg::M_DOT, sll_pkg::M_FRAC:
                begin
                    if (digit)
                    begin
                        cont = 1'b1;
                        mode_next = sll_pkg::M_FRAC;
                    end
                end
                sll_pkg::M_STRING:
                begin
                    cont = 1'b1;
                    if (c == 8'h22)
                    begin
                        t[0] = '{sll_pkg::K_STRING, lo16(start_reg),
                                 span16(start_reg, pos_reg, 1'b1), line_reg};
                        n = 2'd1;
                        mode_next = sll_pkg::M_IDLE;
                    end
                    else if (c == 8'h0A) line_next = line_up;
                end
                sll_pkg::M_SLASH, sll_pkg::M_STAR:
                begin
                    if ((mode_reg == sll_pkg::M_SLASH && c == "/") ||
                        (mode_reg == sll_pkg::M_STAR && c == "*"))
                    begin
                        cont = 1'b1;
                        t[0] = '{(mode_reg == sll_pkg::M_SLASH) ? sll_pkg::K_SLASH2
                                                                 : sll_pkg::K_STAR2,
                                 lo16(start_reg), 16'd2, line_reg};
                        n = 2'd1;
                        mode_next = sll_pkg::M_IDLE;
                    end
                end
                sll_pkg::M_EQ, sll_pkg::M_LT, sll_pkg::M_GT, sll_pkg::M_BANG:
                begin
                    if (c == "=")
                    begin
                        cont = 1'b1;
                        t[0].kind = (mode_reg == sll_pkg::M_EQ) ? sll_pkg::K_EQ_EQ :
                                    (mode_reg == sll_pkg::M_LT) ? sll_pkg::K_LESS_EQ :
                                    (mode_reg == sll_pkg::M_GT) ? sll_pkg::K_GREATER_EQ :
                                    sll_pkg::K_BANG_EQ;
                        t[0].start = lo16(start_reg);
                        t[0].len = 16'd2;
                        t[0].line = line_reg;
                        n = 2'd1;
                        mode_next = sll_pkg::M_IDLE;
                    end
                end
                default: cont = 1'b0;
            endcase
        end

        // flush the pending token
        if (eoi || !cont)
        begin
            case (mode_reg)
                sll_pkg::M_IDENT:
                begin
                    t[0].start = lo16(start_reg);
                    t[0].len = span16(start_reg, pos_reg, 1'b0);
                    t[0].kind = (pos_reg >= start_reg && idx <= POSITION_BITS'(sll_pkg::KW_LEN))
                              ? sll_pkg::kw_lookup(kw_reg, idx[3:0]) : sll_pkg::K_IDENT;
                    t[0].line = line_reg;
                    n = 2'd1;
                end
                sll_pkg::M_INT, sll_pkg::M_FRAC:
                begin
                    t[0] = '{sll_pkg::K_NUMBER, lo16(start_reg),
                             span16(start_reg, pos_reg, 1'b0), line_reg};
                    n = 2'd1;
                end
                sll_pkg::M_DOT:
                begin
                    t[0] = '{sll_pkg::K_NUMBER, lo16(start_reg),
                             span16(start_reg, dot_reg, 1'b0), line_reg};
                    t[1] = '{sll_pkg::K_DOT, lo16(dot_reg), 16'd1, line_reg};
                    n = 2'd2;
                end
                sll_pkg::M_STRING:
                begin
                    t[0] = '{sll_pkg::K_ERR_STRING, lo16(start_reg),
                             span16(start_reg, pos_reg, 1'b0), line_reg};
                    n = 2'd1;
                end
                sll_pkg::M_SLASH, sll_pkg::M_STAR, sll_pkg::M_EQ, sll_pkg::M_LT,
                sll_pkg::M_GT, sll_pkg::M_BANG:
                begin
                    t[0].kind = (mode_reg == sll_pkg::M_SLASH) ? sll_pkg::K_SLASH :
                                (mode_reg == sll_pkg::M_STAR) ? sll_pkg::K_STAR :
                                (mode_reg == sll_pkg::M_EQ) ? sll_pkg::K_EQ :
                                (mode_reg == sll_pkg::M_LT) ? sll_pkg::K_LESS :
                                (mode_reg == sll_pkg::M_GT) ? sll_pkg::K_GREATER :
                                sll_pkg::K_ERR_CHAR;
                    t[0].start = lo16(start_reg);
                    t[0].len = 16'd1;
                    t[0].line = line_reg;
                    n = 2'd1;
                end
                default: n = 2'd0;
            endcase
            mode_next = sll_pkg::M_IDLE;
        end

        if (eoi)
        begin
            // end of file token, then back to reset state
            tk = '{sll_pkg::K_EOF, lo16(pos_reg), 16'd0, line_reg};
            mode_next = sll_pkg::M_IDLE;
            start_next = '0;
            pos_next = '0;
            dot_next = '0;
            line_next = 16'd1;
            kw_next = '0;
        end
        else
        begin
            if (!cont)
            begin
                // start a new token
                start_next = pos_reg;
                tk = '{sll_pkg::K_ERR_CHAR, lo16(pos_reg), 16'd1, line_reg};
                if (alpha)
                begin
                    kw_next = '0;
                    kw_next[0] = c;
                    mode_next = sll_pkg::M_IDENT;
                    tk.len = 16'd0;
                end
                else if (digit)
                begin
                    mode_next = sll_pkg::M_INT;
                    tk.len = 16'd0;
                end
                else
                begin
                    case (c)
                        " ", 8'h0D, 8'h09: tk.len = 16'd0;
                        8'h0A:
                        begin
                            line_next = line_up;
                            tk.len = 16'd0;
                        end
                        "#": begin mode_next = sll_pkg::M_COMMENT; tk.len = 16'd0; end
                        8'h22: begin mode_next = sll_pkg::M_STRING; tk.len = 16'd0; end
                        "(": tk.kind = sll_pkg::K_LPAREN;
                        ")": tk.kind = sll_pkg::K_RPAREN;
                        ";": tk.kind = sll_pkg::K_SEMI;
                        ",": tk.kind = sll_pkg::K_COMMA;
                        ".": tk.kind = sll_pkg::K_DOT;
                        "-": tk.kind = sll_pkg::K_MINUS;
                        "+": tk.kind = sll_pkg::K_PLUS;
                        "%": tk.kind = sll_pkg::K_PERCENT;
                        "/": begin mode_next = sll_pkg::M_SLASH; tk.len = 16'd0; end
                        "*": begin mode_next = sll_pkg::M_STAR; tk.len = 16'd0; end
                        "=": begin mode_next = sll_pkg::M_EQ; tk.len = 16'd0; end
                        "<": begin mode_next = sll_pkg::M_LT; tk.len = 16'd0; end
                        ">": begin mode_next = sll_pkg::M_GT; tk.len = 16'd0; end
                        "!": begin mode_next = sll_pkg::M_BANG; tk.len = 16'd0; end
                        default: tk.kind = sll_pkg::K_ERR_CHAR;
                    endcase
                end
            end
            if (pos_reg != POS_MAX) pos_next = pos_reg + 1'b1;
        end

        // append the byte's own token; outside end of input a length of zero marks none
        if (eoi || (!cont && tk.len != 16'd0))
        begin
            tk.line = line_reg;
            case (n)
                2'd0: t[0] = tk;
                2'd1: t[1] = tk;
                default: t[2] = tk;
            endcase
            n = n + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sll_pkg::M_IDLE;
            start_reg <= '0;
            pos_reg <= '0;
            dot_reg <= '0;
            line_reg <= 16'd1;
            kw_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            start_reg <= start_next;
            pos_reg <= pos_next;
            dot_reg <= dot_next;
            line_reg <= line_next;
            kw_reg <= kw_next;
        end
    end

    assign tok_count = n;
    assign tok0 = t[0];
    assign tok1 = t[1];
    assign tok2 = t[2];
endmodule

>>> src/sll_outq.sv
// result queue: holds the tokens of accepted bytes and sends one per cycle while out_stall is low
module sll_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [1:0]         push_count,
    input  sll_pkg::tok_t      push0,
    input  sll_pkg::tok_t      push1,
    input  sll_pkg::tok_t      push2,
    output logic               space_ok,
    output logic               out_valid,
    input  logic               out_stall,
    output sll_pkg::out_item_t out_item
);
    // eight entries: up to five queued plus a full group of three
    typedef struct packed {
        sll_pkg::tok_t tok;
        logic          last;
    } ent_t;

    ent_t q_reg [8];
    logic [2:0] rd_reg, wr_reg;
    logic [3:0] cnt_reg, cnt_next;
    logic pop;

    assign out_valid = cnt_reg != 4'd0;
    assign pop = out_valid && !out_stall;
    assign space_ok = cnt_reg <= 4'd5;
    assign out_item = '{q_reg[rd_reg].tok.kind, q_reg[rd_reg].tok.start,
                        q_reg[rd_reg].tok.len, q_reg[rd_reg].tok.line, q_reg[rd_reg].last};

    always_comb
    begin
        cnt_next = cnt_reg - {3'd0, pop} + ((push) ? {2'd0, push_count} : 4'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{push0, push_count == 2'd1};
            q_reg[wr_reg + 3'd1] <= '{push1, push_count == 2'd2};
            q_reg[wr_reg + 3'd2] <= '{push2, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (pop) rd_reg <= rd_reg + 3'd1;
            if (push) wr_reg <= wr_reg + {1'b0, push_count};
            cnt_reg <= cnt_next;
        end
    end
endmodule

>>> src/sll_checker.sv
// port-level checker for the script language lexer, bound to the top level
module sll_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input sll_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input sll_pkg::out_item_t out_item
);
    // a stalled token holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled token changed");

    // end of file tokens close a run and have zero length
    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.token_kind == sll_pkg::K_EOF |->
        out_item.last_of_run && out_item.token_length == 16'd0)
        else $error("bad end of file token");

    // kinds stay in the defined code range
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.token_kind <= sll_pkg::K_ERR_STRING)
        else $error("token kind out of range");

    // lines never read zero
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.line_number != 16'd0)
        else $error("line number zero");

    // an accepted end-of-input yields a token next cycle
    a_eoi: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.end_of_input |=> out_valid)
        else $error("no token after end of input");
endmodule

bind script_language_lexer sll_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
